// ===== rtl/rsbt_pkg.sv =====
`timescale 1ns / 1ps
package rsbt_pkg;

   localparam int DEC_WIDTH = 3;

   localparam logic [DEC_WIDTH-1:0] DEC_INSIDE = 3'd0;
   localparam logic [DEC_WIDTH-1:0] DEC_HIT    = 3'd1;
   localparam logic [DEC_WIDTH-1:0] DEC_FAR    = 3'd2;
   localparam logic [DEC_WIDTH-1:0] DEC_MISS   = 3'd3;
   localparam logic [DEC_WIDTH-1:0] DEC_ENTRY  = 3'd4;
   localparam logic [DEC_WIDTH-1:0] DEC_BEHIND = 3'd5;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [1:0] CSR_RADIUS   = 2'd3;

   localparam int QUEUE_DEPTH = 8;
   localparam int OUT_DEPTH   = 8;

   typedef struct packed {
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] center_z;
      logic [30:0] radius;
   } cfg_type;

   // word handed from the front end to the back end
   typedef struct packed {
      logic                 decided;
      logic [DEC_WIDTH-1:0] code;
      logic                 tneg;
      logic [36:0]          tmag;
      logic [65:0]          e;
      logic [31:0]          m;
   } mid_type;

   typedef struct packed {
      logic                 hit;
      logic [DEC_WIDTH-1:0] decision;
   } rsp_type;

endpackage

// ===== rtl/ray_sphere_bound_test.sv =====
`timescale 1ns / 1ps
// Ray against bounding sphere test. One ray word may be accepted every cycle
// while req_stall is low. With both queues empty, its result word passes three
// front stages, the 8-word queue, three back stages and the 8-word result queue
// before it shows on rsp_*. Every stage is fully pipelined, so throughput is
// one ray per cycle while req_stall is low. req_stall rises only when the
// queues would overflow from a stalled result side. The user must write sphere
// registers through csr_* only while no ray is in flight; it is not enforced.
module ray_sphere_bound_test #(
   parameter int COORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_eye_x,
   input  logic [31:0] req_eye_y,
   input  logic [31:0] req_eye_z,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   input  logic [31:0] req_max_distance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [2:0]  rsp_decision
);
   import rsbt_pkg::*;

   cfg_type cfg_ff;

   logic    q_push, q_pop, q_empty;
   mid_type q_wr, q_rd;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

   logic    o_push, o_pop, o_empty;
   rsp_type o_wr, o_rd;
   logic [$clog2(OUT_DEPTH+1)-1:0] o_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CENTER_X: cfg_ff.center_x <= csr_wdata;
            CSR_CENTER_Y: cfg_ff.center_y <= csr_wdata;
            CSR_CENTER_Z: cfg_ff.center_z <= csr_wdata;
            CSR_RADIUS:   cfg_ff.radius   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   rsbt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_eye_x        (req_eye_x),
      .req_eye_y        (req_eye_y),
      .req_eye_z        (req_eye_z),
      .req_dir_x        (req_dir_x),
      .req_dir_y        (req_dir_y),
      .req_dir_z        (req_dir_z),
      .req_max_distance (req_max_distance),
      .q_count          (q_count),
      .q_push           (q_push),
      .q_word           (q_wr)
   );

   rsbt_fifo #(.WIDTH($bits(mid_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .rd_data (q_rd),
      .empty   (q_empty),
      .count   (q_count)
   );

   rsbt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_word  (q_rd),
      .q_pop   (q_pop),
      .o_count (o_count),
      .o_push  (o_push),
      .o_word  (o_wr)
   );

   rsbt_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(OUT_DEPTH)) u_out (
      .clock   (clock),
      .reset   (reset),
      .push    (o_push),
      .wr_data (o_wr),
      .pop     (o_pop),
      .rd_data (o_rd),
      .empty   (o_empty),
      .count   (o_count)
   );

   assign rsp_valid    = !o_empty;
   assign o_pop        = rsp_valid && !rsp_stall;
   assign rsp_hit      = o_rd.hit;
   assign rsp_decision = o_rd.decision;
endmodule

// ===== rtl/rsbt_fifo.sv =====
`timescale 1ns / 1ps
module rsbt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
endmodule

// ===== rtl/rsbt_front.sv =====
`timescale 1ns / 1ps
module rsbt_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsbt_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_eye_x,
   input  logic [31:0]          req_eye_y,
   input  logic [31:0]          req_eye_z,
   input  logic [31:0]          req_dir_x,
   input  logic [31:0]          req_dir_y,
   input  logic [31:0]          req_dir_z,
   input  logic [31:0]          req_max_distance,
   input  logic [$clog2(rsbt_pkg::QUEUE_DEPTH+1)-1:0] q_count,
   output logic                 q_push,
   output rsbt_pkg::mid_type    q_word
);
   import rsbt_pkg::*;

   localparam int CWE = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int QCW = $clog2(QUEUE_DEPTH+1);

   logic accept;

   // stage A: L = C - E
   logic               va_ff;
   logic signed [32:0] lx_ff, ly_ff, lz_ff, lx_in, ly_in, lz_in;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic [31:0]        ma_ff;

   // stage B: products
   logic               vb_ff;
   logic [63:0]        sqx_ff, sqy_ff, sqz_ff;
   logic signed [64:0] px_ff, py_ff, pz_ff;
   logic [61:0]        r2b_ff;
   logic [65:0]        mr2b_ff;
   logic [31:0]        mb_ff;
   logic [31:0]        ax, ay, az;
   logic [32:0]        mr;

   // stage C: sums
   logic               vc_ff;
   logic [65:0]        s_ff;
   logic signed [66:0] dot_ff;
   logic [61:0]        r2c_ff;
   logic [65:0]        mr2c_ff;
   logic [31:0]        mc_ff;

   logic [36:0]        t;
   logic [QCW:0]       credit;

   assign credit    = (QCW+1)'(q_count) + (QCW+1)'(va_ff) + (QCW+1)'(vb_ff)
                      + (QCW+1)'(vc_ff);
   assign req_stall = (credit >= (QCW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign lx_in = 33'($signed(cfg.center_x[CWE-1:0])) - 33'($signed(req_eye_x[CWE-1:0]));
   assign ly_in = 33'($signed(cfg.center_y[CWE-1:0])) - 33'($signed(req_eye_y[CWE-1:0]));
   assign lz_in = 33'($signed(cfg.center_z[CWE-1:0])) - 33'($signed(req_eye_z[CWE-1:0]));

   assign ax = lx_ff[32] ? 32'(-lx_ff) : lx_ff[31:0];
   assign ay = ly_ff[32] ? 32'(-ly_ff) : ly_ff[31:0];
   assign az = lz_ff[32] ? 32'(-lz_ff) : lz_ff[31:0];
   assign mr = {1'b0, ma_ff} + {2'b0, cfg.radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      lx_ff <= lx_in;
      ly_ff <= ly_in;
      lz_ff <= lz_in;
      dx_ff <= req_dir_x;
      dy_ff <= req_dir_y;
      dz_ff <= req_dir_z;
      ma_ff <= req_max_distance;

      sqx_ff  <= ax * ax;
      sqy_ff  <= ay * ay;
      sqz_ff  <= az * az;
      px_ff   <= lx_ff * dx_ff;
      py_ff   <= ly_ff * dy_ff;
      pz_ff   <= lz_ff * dz_ff;
      r2b_ff  <= cfg.radius * cfg.radius;
      mr2b_ff <= mr * mr;
      mb_ff   <= ma_ff;

      s_ff    <= 66'(sqx_ff) + 66'(sqy_ff) + 66'(sqz_ff);
      dot_ff  <= 67'(px_ff) + 67'(py_ff) + 67'(pz_ff);
      r2c_ff  <= r2b_ff;
      mr2c_ff <= mr2b_ff;
      mc_ff   <= mb_ff;
   end

   // classify: inside and too-far are settled here, the rest goes on
   assign t = dot_ff[66:30];

   always_comb begin
      q_word.tneg = dot_ff[66];
      q_word.tmag = dot_ff[66] ? 37'(-t) : t;
      q_word.e    = s_ff - 66'(r2c_ff);
      q_word.m    = mc_ff;
      if (s_ff < 66'(r2c_ff)) begin
         q_word.decided = 1'b1;
         q_word.code    = DEC_INSIDE;
      end else if (s_ff >= mr2c_ff) begin
         q_word.decided = 1'b1;
         q_word.code    = DEC_FAR;
      end else begin
         q_word.decided = 1'b0;
         q_word.code    = DEC_HIT;
      end
   end

   assign q_push = vc_ff;
endmodule

// ===== rtl/rsbt_back.sv =====
`timescale 1ns / 1ps
module rsbt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  rsbt_pkg::mid_type    q_word,
   output logic                 q_pop,
   input  logic [$clog2(rsbt_pkg::OUT_DEPTH+1)-1:0] o_count,
   output logic                 o_push,
   output rsbt_pkg::rsp_type    o_word
);
   import rsbt_pkg::*;

   localparam int OCW = $clog2(OUT_DEPTH+1);

   logic [OCW:0] credit;

   logic     vp_ff, v1_ff, v2_ff;
   mid_type  p_ff;

   logic                 dec1_ff, tneg1_ff, ge1_ff;
   logic [DEC_WIDTH-1:0] code1_ff;
   logic [73:0]          t21_ff;
   logic [36:0]          dd1_ff;
   logic [65:0]          e1_ff;

   logic                 dec2_ff, tneg2_ff, ge2_ff, miss2_ff;
   logic [DEC_WIDTH-1:0] code2_ff;
   logic [73:0]          d22_ff, h22_ff;

   logic entry;

   assign credit = (OCW+1)'(o_count) + (OCW+1)'(vp_ff) + (OCW+1)'(v1_ff)
                   + (OCW+1)'(v2_ff);
   assign q_pop  = !q_empty && (credit < (OCW+1)'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         vp_ff <= q_pop;
         v1_ff <= vp_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= q_word;

      dec1_ff  <= p_ff.decided;
      code1_ff <= p_ff.code;
      tneg1_ff <= p_ff.tneg;
      ge1_ff   <= (p_ff.tmag >= 37'(p_ff.m));
      dd1_ff   <= p_ff.tmag - 37'(p_ff.m);
      t21_ff   <= p_ff.tmag * p_ff.tmag;
      e1_ff    <= p_ff.e;

      dec2_ff  <= dec1_ff;
      code2_ff <= code1_ff;
      tneg2_ff <= tneg1_ff;
      ge2_ff   <= ge1_ff;
      miss2_ff <= (74'(e1_ff) >= t21_ff);
      h22_ff   <= t21_ff - 74'(e1_ff);
      d22_ff   <= dd1_ff * dd1_ff;
   end

   assign entry = !tneg2_ff && ge2_ff && (d22_ff >= h22_ff);

   always_comb begin
      o_word.hit = 1'b0;
      if (dec2_ff) begin
         o_word.decision = code2_ff;
         o_word.hit      = (code2_ff == DEC_INSIDE);
      end else if (miss2_ff) begin
         o_word.decision = DEC_MISS;
      end else if (entry) begin
         o_word.decision = DEC_ENTRY;
      end else if (tneg2_ff) begin
         o_word.decision = DEC_BEHIND;
      end else begin
         o_word.decision = DEC_HIT;
         o_word.hit      = 1'b1;
      end
   end

   assign o_push = v2_ff;
endmodule

// ===== rtl/rsbt_checker.sv =====
`timescale 1ns / 1ps
module rsbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [2:0]  rsp_decision
);
   import rsbt_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   a_stall_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_decision))
      else $error("stalled result word changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_decision <= DEC_BEHIND)
      else $error("decision code out of range");

   a_hit_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit == (rsp_decision == DEC_INSIDE || rsp_decision == DEC_HIT))
      else $error("hit bit disagrees with decision");
endmodule

bind ray_sphere_bound_test rsbt_checker u_rsbt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_hit      (rsp_hit),
   .rsp_decision (rsp_decision)
);

// ===== verif/ray_sphere_bound_test_tb.sv =====
`timescale 1ns / 1ps
module ray_sphere_bound_test_tb;
   import rsbt_pkg::*;

   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [31:0] eye_x, eye_y, eye_z;
      logic [31:0] dir_x, dir_y, dir_z;
      logic [31:0] max_distance;
   } ray_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_CENTER_X;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [31:0] req_max_distance = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic [2:0]  rsp_decision;

   // sphere as the predictor sees it
   logic signed [31:0] sph_cx = 0, sph_cy = 0, sph_cz = 0;
   logic [30:0]        sph_r = 0;

   rsp_type expected_q[$];
   int      error_count = 0;
   int      rays_sent = 0;
   int      results_seen = 0;
   int      dec_seen[6];
   longint  cycle_count = 0;
   bit      long_hold = 1'b0;
   bit      burst_mode = 1'b1;

   always #5 clock = ~clock;

   ray_sphere_bound_test dut (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  expected_q.size());
         $display("[ray_sphere_bound_test] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // exact integer form of the ray/sphere test
   function automatic rsp_type sphere_verdict(ray_type ray);
      logic signed [33:0]  lx, ly, lz;
      logic signed [127:0] s, r2, dot, t2, e, h2, lim, tq, mq;
      logic signed [127:0] tv, mv, rv;
      rsp_type res;
      lx = 34'(sph_cx) - 34'(signed'(ray.eye_x));
      ly = 34'(sph_cy) - 34'(signed'(ray.eye_y));
      lz = 34'(sph_cz) - 34'(signed'(ray.eye_z));
      rv = 128'(sph_r);
      mv = 128'(ray.max_distance);
      s = 128'(lx) * 128'(lx) + 128'(ly) * 128'(ly) + 128'(lz) * 128'(lz);
      r2 = rv * rv;
      lim = (mv + rv) * (mv + rv);
      res.hit = 1'b0;
      if (s < r2) begin
         res.hit = 1'b1;
         res.decision = DEC_INSIDE;
      end else if (s >= lim) begin
         res.decision = DEC_FAR;
      end else begin
         dot = 128'(lx) * 128'(signed'(ray.dir_x)) + 128'(ly) * 128'(signed'(ray.dir_y))
             + 128'(lz) * 128'(signed'(ray.dir_z));
         tv = dot >>> 30;
         t2 = tv * tv;
         e = s - r2;
         if (e >= t2) begin
            res.decision = DEC_MISS;
         end else begin
            h2 = t2 - e;
            tq = tv - mv;
            mq = tq * tq;
            if (tv >= 0 && tv >= mv && mq >= h2) res.decision = DEC_ENTRY;
            else if (tv < 0) res.decision = DEC_BEHIND;
            else begin
               res.hit = 1'b1;
               res.decision = DEC_HIT;
            end
         end
      end
      return res;
   endfunction

   task automatic write_sphere(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CENTER_X: sph_cx = value;
         CSR_CENTER_Y: sph_cy = value;
         CSR_CENTER_Z: sph_cz = value;
         CSR_RADIUS:   sph_r  = value[30:0];
         default: ;
      endcase
   endtask

   task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] r);
      write_sphere(CSR_CENTER_X, cx);
      write_sphere(CSR_CENTER_Y, cy);
      write_sphere(CSR_CENTER_Z, cz);
      write_sphere(CSR_RADIUS, {1'b0, r});
   endtask

   // send one ray word; called at a falling edge, returns at a falling edge
   task automatic send_ray(input ray_type ray);
      int gap;
      if (!burst_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_eye_x <= ray.eye_x;
      req_eye_y <= ray.eye_y;
      req_eye_z <= ray.eye_z;
      req_dir_x <= ray.dir_x;
      req_dir_y <= ray.dir_y;
      req_dir_z <= ray.dir_z;
      req_max_distance <= ray.max_distance;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(sphere_verdict(ray));
      rays_sent++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (long_hold) rsp_stall <= 1'b1;
      else if (cycle_count % 700 < 150) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_q.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %b, want %b", rsp_hit, want.hit));
            if (rsp_decision !== want.decision)
               report_mismatch($sformatf("decision %0d, want %0d", rsp_decision,
                                         want.decision));
            if (want.decision <= DEC_BEHIND) dec_seen[want.decision]++;
         end
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: return $urandom;
      endcase
   endfunction

   // unit-ish direction, sometimes junk
   function automatic ray_type aimed_ray(input bit wild);
      ray_type ray;
      int k;
      ray.eye_x = sph_cx + 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      ray.eye_y = sph_cy + 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      ray.eye_z = sph_cz + 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      ray.dir_x = 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      ray.dir_y = 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      k = $urandom_range(0, 2);
      ray.dir_z = $urandom_range(0, 1) ? 32'h3000_0000 : 32'hd000_0000;
      if (k == 0) ray.dir_z = 32'h4000_0000;
      ray.max_distance = $urandom_range(0, 32'h0040_0000);
      if (wild) begin
         ray.eye_x = pick_coord();
         ray.eye_y = pick_coord();
         ray.eye_z = pick_coord();
         ray.dir_x = $urandom;
         ray.dir_y = $urandom;
         ray.dir_z = $urandom;
         ray.max_distance = $urandom_range(0, 1) ? 32'hffff_ffff : $urandom;
      end
      return ray;
   endfunction

   task automatic test_directed();
      ray_type ray;
      burst_mode = 1'b1;
      set_sphere(32'h0000_0000, 32'h0000_0000, 32'h000a_0000, 31'h0002_0000);
      // on axis toward sphere: hit
      ray = '{0, 0, 0, 0, 0, 32'h4000_0000, 32'h0064_0000};
      send_ray(ray);
      // eye inside
      ray.eye_z = 32'h000a_0000;
      send_ray(ray);
      // center too far
      ray = '{0, 0, 0, 0, 0, 32'h4000_0000, 32'h0001_0000};
      send_ray(ray);
      // entry too far: grazing ray whose near crossing lies past the limit
      ray = '{32'h0001_e666, 0, 0, 0, 0, 32'h4000_0000, 32'h0009_0000};
      send_ray(ray);
      // miss sideways
      ray = '{32'h0005_0000, 0, 0, 0, 0, 32'h4000_0000, 32'h0064_0000};
      send_ray(ray);
      // behind eye
      ray = '{0, 0, 0, 0, 0, 32'hc000_0000, 32'h0064_0000};
      send_ray(ray);
      // edge on the sphere surface
      ray = '{0, 0, 32'h0008_0000, 0, 0, 32'h4000_0000, 0};
      send_ray(ray);
      // field extremes
      ray = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff};
      send_ray(ray);
      ray = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff};
      send_ray(ray);
      ray = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0,
              32'h7fff_ffff, 32'h0};
      send_ray(ray);
      go_idle();
      // extreme sphere
      set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
      ray = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
      send_ray(ray);
      ray = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0};
      send_ray(ray);
      ray = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h0};
      send_ray(ray);
      go_idle();
   endtask

   task automatic test_random(input int count);
      int left;
      left = count;
      while (left > 0) begin
         burst_mode = $urandom_range(0, 2) == 0;
         repeat ($urandom_range(1, 40)) begin
            if (left > 0) begin
               send_ray(aimed_ray($urandom_range(0, 4) == 0));
               left--;
            end
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      go_idle();
   endtask

   task automatic test_backpressure();
      burst_mode = 1'b1;
      fork
         begin
            long_hold = 1'b1;
            repeat (300) @(negedge clock);
            long_hold = 1'b0;
         end
         repeat (80) send_ray(aimed_ray(1'b0));
      join
      go_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset sphere is a point at the origin
      test_directed();
      set_sphere(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0001_8000);
      test_random(300);
      set_sphere(pick_coord(), pick_coord(), pick_coord(), 31'($urandom_range(0, 32'h0008_0000)));
      test_random(300);
      set_sphere(32'hfff0_0000, 32'h0010_0000, 32'h0003_0000, 31'h0);
      test_random(200);
      set_sphere($urandom, $urandom, $urandom, 31'h7fff_ffff);
      test_random(150);
      set_sphere(32'h0001_0000, 32'hffff_0000, 32'h0, 31'h000c_0000);
      test_backpressure();
      test_random(350);
      $display("%0d rays sent, %0d results checked, %0d cycles", rays_sent,
               results_seen, cycle_count);
      $display("decisions: inside %0d hit %0d far %0d miss %0d entry %0d behind %0d",
               dec_seen[0], dec_seen[1], dec_seen[2], dec_seen[3], dec_seen[4],
               dec_seen[5]);
      if (error_count == 0 && expected_q.size() == 0)
         $display("[ray_sphere_bound_test] OK");
      else
         $display("[ray_sphere_bound_test] ERROR");
      $finish;
   end

endmodule
